[rtl/lmsd_pkg.sv]
`default_nettype none

package lmsd_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PAINT = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] plane;
    logic [7:0] byte_address;
    logic [7:0] byte_data;
  } in_item_t;

  typedef struct packed {
    logic       red_upper_pin;
    logic       green_upper_pin;
    logic       red_lower_pin;
    logic       green_lower_pin;
    logic       shift_pulse;
    logic [3:0] row_select;
    logic       latch_pulse;
    logic       blank_n_enable;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    BEAT_NONE,
    BEAT_SHIFT,
    BEAT_LATCH,
    BEAT_BLANK
  } beat_e;

  // sequencing of the step counter
  typedef enum logic [2:0] {
    SEQ_NEXT,      // step + 1
    SEQ_DISPATCH,  // decode the accepted command
    SEQ_COPY,      // stay until the copy pointer reaches the end
    SEQ_ROW_END,   // jump to target at end of row, else idle
    SEQ_FRAME_END, // jump to target after last row, else idle
    SEQ_IDLE       // back to idle
  } seq_e;

  localparam int unsigned StepW = 4;

  localparam logic [StepW-1:0] STEP_IDLE     = 4'd0;
  localparam logic [StepW-1:0] STEP_COPY     = 4'd1;
  localparam logic [StepW-1:0] STEP_COPY_END = 4'd2;
  localparam logic [StepW-1:0] STEP_READ     = 4'd3;
  localparam logic [StepW-1:0] STEP_SHIFT0   = 4'd4;
  localparam logic [StepW-1:0] STEP_SHIFT1   = 4'd5;
  localparam logic [StepW-1:0] STEP_SHIFT2   = 4'd6;
  localparam logic [StepW-1:0] STEP_SHIFT3   = 4'd7;
  localparam logic [StepW-1:0] STEP_LATCH    = 4'd8;
  localparam logic [StepW-1:0] STEP_BLANK    = 4'd9;

  typedef struct packed {
    logic             take_in;
    logic             copy_rd;
    logic             scan_rd;
    beat_e            beat;
    logic [1:0]       pair;
    logic             adv_col;
    logic             adv_row;
    seq_e             seq;
    logic [StepW-1:0] target;
  } uc_word_t;

  function automatic uc_word_t uc_rom(input logic [StepW-1:0] step);
    uc_word_t w;
    w = '{take_in: 1'b0, copy_rd: 1'b0, scan_rd: 1'b0, beat: BEAT_NONE, pair: 2'd0,
          adv_col: 1'b0, adv_row: 1'b0, seq: SEQ_IDLE, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.seq     = SEQ_DISPATCH;
      end
      STEP_COPY: begin
        w.copy_rd = 1'b1;
        w.seq     = SEQ_COPY;
        w.target  = STEP_COPY_END;
      end
      STEP_COPY_END: w.seq = SEQ_IDLE;
      STEP_READ: begin
        w.scan_rd = 1'b1;
        w.seq     = SEQ_NEXT;
      end
      STEP_SHIFT0, STEP_SHIFT1, STEP_SHIFT2: begin
        w.beat = BEAT_SHIFT;
        w.pair = 2'(step - STEP_SHIFT0);
        w.seq  = SEQ_NEXT;
      end
      STEP_SHIFT3: begin
        w.beat    = BEAT_SHIFT;
        w.pair    = 2'd3;
        w.adv_col = 1'b1;
        w.seq     = SEQ_ROW_END;
        w.target  = STEP_LATCH;
      end
      STEP_LATCH: begin
        w.beat    = BEAT_LATCH;
        w.adv_row = 1'b1;
        w.seq     = SEQ_FRAME_END;
        w.target  = STEP_BLANK;
      end
      STEP_BLANK: begin
        w.beat = BEAT_BLANK;
        w.seq  = SEQ_IDLE;
      end
      default: w.seq = SEQ_IDLE;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/lmsd_ram.sv]
`default_nettype none

module lmsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/led_matrix_scan_driver.sv]
// Scan driver for a two-color LED matrix with multiplexed rows, double buffered.
// Input channel (in_valid_i / in_stall_o, in_item_i) takes one command per item:
//   write - stores byte_data in the draw store; no output item.
//   paint - copies the draw store into the display store, one byte per cycle in
//           each half; no output item.
//   step  - reads one upper/lower byte pair from the display store and
//           sends four shift beats, plus a latch beat at the end of a row and a
//           blanking beat after the last row. The first beat is registered into
//           the output after the read, then one beat per cycle while out_stall_i
//           does not hold the output.
// Each store has one read port, which sets the paint length; a step is the accept,
// the read and the beats. One command is handled at a time: in_stall_o is low only
// while the sequencer waits at its idle step.
// Output channel (out_valid_o / out_stall_i, out_item_o) carries one beat per
// item; last marks the final beat of a step. A stall holds the beat in the output
// register and the sequencer waits at the next beat.
// Reset clears the sequencer and the scan position (row 0, panel 0, column 0);
// store contents are undefined until written.
`default_nettype none

module led_matrix_scan_driver #(
  parameter int unsigned PANELS        = 1,
  parameter int unsigned ROWS          = 16,
  parameter int unsigned BYTES_PER_ROW = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire lmsd_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lmsd_pkg::out_item_t      out_item_o
);

  import lmsd_pkg::*;

  localparam int unsigned PlaneBytes = ROWS * BYTES_PER_ROW;
  localparam int unsigned BankDepth  = PANELS * PlaneBytes;
  localparam int unsigned AddrW      = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int unsigned ColW       = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int unsigned RowW       = $clog2(ROWS);

  logic [StepW-1:0] step_q, step_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             panel_q, panel_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] row_base_q, row_base_d;
  logic [AddrW-1:0] copy_ptr_q, copy_ptr_d;
  logic [AddrW-1:0] copy_waddr_q;
  logic             copy_wv_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  uc_word_t   uc;
  logic       in_acc;
  logic       emit_ok, emit, busy;
  logic       col_last, row_end, frame_end, copy_last;
  logic       wr_ok, draw_we_up, draw_we_lo;
  logic [AddrW-1:0] wr_addr, scan_addr;
  logic [7:0] draw_up_rd, draw_lo_rd, disp_up_rd, disp_lo_rd;
  logic [1:0] up_px, lo_px;

  assign uc         = uc_rom(step_q);
  assign in_stall_o = !uc.take_in;
  assign in_acc     = in_valid_i && uc.take_in;

  assign emit_ok = !out_valid_q || !out_stall_i;
  assign emit    = (uc.beat != BEAT_NONE) && emit_ok;
  assign busy    = (uc.beat != BEAT_NONE) && !emit_ok;

  assign col_last  = col_q == ColW'(BYTES_PER_ROW - 1);
  assign row_end   = col_last && (panel_q == 1'(PANELS - 1));
  assign frame_end = row_q == RowW'(ROWS - 1);
  assign copy_last = copy_ptr_q == AddrW'(BankDepth - 1);

  // write decode: plane of a missing panel or address past the plane is dropped
  assign wr_ok = ((PANELS > 1) || !in_item_i.plane[1]) &&
                 (32'(in_item_i.byte_address) < PlaneBytes);
  assign wr_addr = (in_item_i.plane[1] ? AddrW'(PlaneBytes) : '0) +
                   AddrW'(in_item_i.byte_address);
  assign draw_we_up = in_acc && (in_item_i.cmd == CMD_WRITE) && wr_ok && !in_item_i.plane[0];
  assign draw_we_lo = in_acc && (in_item_i.cmd == CMD_WRITE) && wr_ok && in_item_i.plane[0];

  assign scan_addr = (panel_q ? AddrW'(PlaneBytes) : '0) + row_base_q + AddrW'(col_q);

  lmsd_ram #(.Width(8), .Depth(BankDepth), .AddrW(AddrW)) u_draw_up (
    .clk_i   (clk_i),
    .we_i    (draw_we_up),
    .waddr_i (wr_addr),
    .wdata_i (in_item_i.byte_data),
    .re_i    (uc.copy_rd),
    .raddr_i (copy_ptr_q),
    .rdata_o (draw_up_rd)
  );

  lmsd_ram #(.Width(8), .Depth(BankDepth), .AddrW(AddrW)) u_draw_lo (
    .clk_i   (clk_i),
    .we_i    (draw_we_lo),
    .waddr_i (wr_addr),
    .wdata_i (in_item_i.byte_data),
    .re_i    (uc.copy_rd),
    .raddr_i (copy_ptr_q),
    .rdata_o (draw_lo_rd)
  );

  lmsd_ram #(.Width(8), .Depth(BankDepth), .AddrW(AddrW)) u_disp_up (
    .clk_i   (clk_i),
    .we_i    (copy_wv_q),
    .waddr_i (copy_waddr_q),
    .wdata_i (draw_up_rd),
    .re_i    (uc.scan_rd),
    .raddr_i (scan_addr),
    .rdata_o (disp_up_rd)
  );

  lmsd_ram #(.Width(8), .Depth(BankDepth), .AddrW(AddrW)) u_disp_lo (
    .clk_i   (clk_i),
    .we_i    (copy_wv_q),
    .waddr_i (copy_waddr_q),
    .wdata_i (draw_lo_rd),
    .re_i    (uc.scan_rd),
    .raddr_i (scan_addr),
    .rdata_o (disp_lo_rd)
  );

  // step counter
  always_comb begin
    step_d = step_q;
    unique case (uc.seq)
      SEQ_NEXT: begin
        if (!busy) step_d = step_q + StepW'(1);
      end
      SEQ_DISPATCH: begin
        if (in_acc) begin
          unique case (in_item_i.cmd)
            CMD_PAINT: step_d = STEP_COPY;
            CMD_STEP:  step_d = STEP_READ;
            default:   step_d = STEP_IDLE;
          endcase
        end
      end
      SEQ_COPY: begin
        if (copy_last) step_d = uc.target;
      end
      SEQ_ROW_END: begin
        if (!busy) step_d = row_end ? uc.target : STEP_IDLE;
      end
      SEQ_FRAME_END: begin
        if (!busy) step_d = frame_end ? uc.target : STEP_IDLE;
      end
      default: begin
        if (!busy) step_d = STEP_IDLE;
      end
    endcase
  end

  // scan position and copy pointer
  always_comb begin
    col_d      = col_q;
    panel_d    = panel_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    copy_ptr_d = copy_ptr_q;
    if (emit && uc.adv_col) begin
      if (col_last) begin
        col_d   = '0;
        panel_d = (panel_q == 1'(PANELS - 1)) ? 1'b0 : 1'b1;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    if (emit && uc.adv_row) begin
      if (frame_end) begin
        row_d      = '0;
        row_base_d = '0;
      end else begin
        row_d      = row_q + RowW'(1);
        row_base_d = row_base_q + AddrW'(BYTES_PER_ROW);
      end
    end
    if (uc.copy_rd) begin
      copy_ptr_d = copy_last ? '0 : copy_ptr_q + AddrW'(1);
    end
  end

  // beat formatting
  assign up_px = disp_up_rd[{uc.pair, 1'b0} +: 2];
  assign lo_px = disp_lo_rd[{uc.pair, 1'b0} +: 2];

  always_comb begin
    out_d = '{red_upper_pin: 1'b1, green_upper_pin: 1'b1, red_lower_pin: 1'b1,
              green_lower_pin: 1'b1, shift_pulse: 1'b0, row_select: 4'd0,
              latch_pulse: 1'b0, blank_n_enable: 1'b1, last: 1'b1};
    unique case (uc.beat)
      BEAT_SHIFT: begin
        out_d.red_upper_pin   = !up_px[0];
        out_d.green_upper_pin = !up_px[1];
        out_d.red_lower_pin   = !lo_px[0];
        out_d.green_lower_pin = !lo_px[1];
        out_d.shift_pulse     = 1'b1;
        out_d.blank_n_enable  = row_q == '0;
        out_d.last            = (uc.pair == 2'd3) && !row_end;
      end
      BEAT_LATCH: begin
        out_d.row_select  = 4'(row_q);
        out_d.latch_pulse = 1'b1;
        out_d.last        = !frame_end;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      col_q       <= '0;
      panel_q     <= 1'b0;
      row_q       <= '0;
      row_base_q  <= '0;
      copy_ptr_q  <= '0;
      copy_wv_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      col_q       <= col_d;
      panel_q     <= panel_d;
      row_q       <= row_d;
      row_base_q  <= row_base_d;
      copy_ptr_q  <= copy_ptr_d;
      copy_wv_q   <= uc.copy_rd;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    copy_waddr_q <= copy_ptr_q;
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import lmsd_pkg::*;

  localparam int STORE_BYTES = 512;
  localparam int ITEM_BITS   = $bits(in_item_t);
  // cmd code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // bytes filled at the start of each plane; steps never scan past them
  localparam int FILL_BYTES   = 24;
  // past the end of row 0, so a latch beat shows up
  localparam int SCAN_STEPS   = FILL_BYTES;
  localparam int TOTAL_ITEMS  = 110;
  localparam int HOLD_CYCLES  = 200;
  // a paint has no output item to wait on
  localparam int DRAIN_CYCLES = 600;

  typedef enum int {
    IDLE_RX_HEAVY,
    IDLE_TX_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  idle_mode_e idle_mode  = IDLE_RX_HEAVY;
  bit         hold_req   = 1'b0;
  int         items_sent = 0;

  class scan_board;
    logic [7:0] draw_bytes  [STORE_BYTES];
    logic [7:0] shown_bytes [STORE_BYTES];
    logic [3:0] scan_col;
    logic [3:0] scan_row;
    out_item_t  pending_beats [$];
    int         failures;

    function new();
      scan_col = '0;
      scan_row = '0;
      failures = 0;
      foreach (draw_bytes[i]) begin
        draw_bytes[i]  = '0;
        shown_bytes[i] = '0;
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function string beat_text(out_item_t b);
      return $sformatf("ru=%b gu=%b rl=%b gl=%b shift=%b row=%0d latch=%b blank=%b last=%b",
                       b.red_upper_pin, b.green_upper_pin, b.red_lower_pin,
                       b.green_lower_pin, b.shift_pulse, b.row_select, b.latch_pulse,
                       b.blank_n_enable, b.last);
    endfunction

    // pins_n order: red upper, green upper, red lower, green lower (active low)
    function void push_beat(logic [3:0] pins_n, logic shift, logic [3:0] row,
                            logic latch, logic blank);
      out_item_t b;
      b.red_upper_pin   = pins_n[0];
      b.green_upper_pin = pins_n[1];
      b.red_lower_pin   = pins_n[2];
      b.green_lower_pin = pins_n[3];
      b.shift_pulse     = shift;
      b.row_select      = row;
      b.latch_pulse     = latch;
      b.blank_n_enable  = blank;
      b.last            = 1'b0;
      pending_beats.push_back(b);
    endfunction

    function void take_command(in_item_t c);
      logic [7:0] up;
      logic [7:0] lo;
      logic       blank;
      out_item_t  tail_beat;
      case (c.cmd)
        CMD_WRITE: begin
          // planes 2 and 3 belong to a panel that is not fitted
          if (!c.plane[1]) draw_bytes[{c.plane[0], c.byte_address}] = c.byte_data;
        end
        CMD_PAINT: shown_bytes = draw_bytes;
        CMD_STEP: begin
          up    = shown_bytes[{1'b0, scan_row, scan_col}];
          lo    = shown_bytes[{1'b1, scan_row, scan_col}];
          blank = (scan_row == '0);
          for (int k = 0; k < 4; k++)
            push_beat(~{lo[2*k+1], lo[2*k], up[2*k+1], up[2*k]}, 1'b1, 4'd0, 1'b0, blank);
          scan_col++;
          if (scan_col == '0) begin
            push_beat(4'hF, 1'b0, scan_row, 1'b1, 1'b1);
            scan_row++;
            if (scan_row == '0) push_beat(4'hF, 1'b0, 4'd0, 1'b0, 1'b1);
          end
          tail_beat      = pending_beats.pop_back();
          tail_beat.last = 1'b1;
          pending_beats.push_back(tail_beat);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      string     bad;
      if (pending_beats.size() == 0) begin
        note_failure({"beat with none pending: ", beat_text(got)});
        return;
      end
      want = pending_beats.pop_front();
      bad  = "";
      if (got.red_upper_pin   !== want.red_upper_pin)   bad = {bad, " red_upper_pin"};
      if (got.green_upper_pin !== want.green_upper_pin) bad = {bad, " green_upper_pin"};
      if (got.red_lower_pin   !== want.red_lower_pin)   bad = {bad, " red_lower_pin"};
      if (got.green_lower_pin !== want.green_lower_pin) bad = {bad, " green_lower_pin"};
      if (got.shift_pulse     !== want.shift_pulse)     bad = {bad, " shift_pulse"};
      if (got.row_select      !== want.row_select)      bad = {bad, " row_select"};
      if (got.latch_pulse     !== want.latch_pulse)     bad = {bad, " latch_pulse"};
      if (got.blank_n_enable  !== want.blank_n_enable)  bad = {bad, " blank_n_enable"};
      if (got.last            !== want.last)            bad = {bad, " last"};
      if (bad != "")
        note_failure($sformatf("mismatch in%s: expected %s, got %s", bad,
                               beat_text(want), beat_text(got)));
    endfunction
  endclass

  scan_board board;

  led_matrix_scan_driver i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int idle_percent(bit receiver);
    case (idle_mode)
      IDLE_RX_HEAVY: return receiver ? 79 : 21;
      IDLE_TX_HEAVY: return receiver ? 21 : 79;
      default:       return 0;
    endcase
  endfunction

  function automatic in_item_t random_item();
    return in_item_t'(ITEM_BITS'($urandom));
  endfunction

  task automatic send_command(input in_item_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_percent(1'b0)) begin
      in_valid_i <= 1'b0;
      in_item_i  <= random_item();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.take_command(in_item_i);
      if (out_valid_o && !out_stall_i) board.check_beat(out_item_o);
    end
  end

  // receiver side: random stall, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < idle_percent(1'b1));
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_item_t c;
    int       pick;
    int       steps;
    bit       pressed;
    board      = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the scanned part of both planes so no step ever reads an unwritten byte
    for (int i = 0; i < FILL_BYTES; i++) begin
      send_command(in_item_t'{CMD_WRITE, 2'd0, i[7:0], 8'($urandom)});
      send_command(in_item_t'{CMD_WRITE, 2'd1, i[7:0], 8'($urandom)});
    end
    send_command(in_item_t'{CMD_PAINT, 2'd0, 8'd0, 8'd0});

    send_command(in_item_t'{CMD_WRITE, 2'd0, 8'd0, 8'h00});
    send_command(in_item_t'{CMD_WRITE, 2'd1, 8'd0, 8'hFF});
    send_command(in_item_t'{CMD_WRITE, 2'd0, 8'd1, 8'hA5});
    send_command(in_item_t'{CMD_WRITE, 2'd1, 8'd1, 8'h5A});
    send_command(in_item_t'{CMD_WRITE, 2'd0, 8'd255, 8'hFF});
    send_command(in_item_t'{CMD_WRITE, 2'd1, 8'd255, 8'h00});
    // missing panel, must not land anywhere
    send_command(in_item_t'{CMD_WRITE, 2'd2, 8'd0, 8'h77});
    send_command(in_item_t'{CMD_WRITE, 2'd3, 8'd255, 8'hC3});
    send_command(in_item_t'{CMD_UNUSED, 2'd3, 8'hFF, 8'hFF});
    send_command(in_item_t'{CMD_PAINT, 2'd0, 8'd0, 8'd0});
    send_command(in_item_t'{CMD_STEP, 2'd0, 8'd0, 8'd0});
    // draw store only; display must keep the painted byte until the next paint
    send_command(in_item_t'{CMD_WRITE, 2'd0, 8'd2, 8'hFF});
    send_command(in_item_t'{CMD_STEP, 2'd3, 8'hFF, 8'hFF});
    send_command(in_item_t'{CMD_STEP, 2'd1, 8'h80, 8'h01});
    send_command(in_item_t'{CMD_PAINT, 2'd0, 8'd0, 8'd0});
    send_command(in_item_t'{CMD_UNUSED, 2'd0, 8'd0, 8'd0});

    steps   = 3;
    pressed = 1'b0;
    while (items_sent < TOTAL_ITEMS || steps < SCAN_STEPS) begin
      if (steps < SCAN_STEPS / 3)          idle_mode = IDLE_RX_HEAVY;
      else if (steps < 2 * SCAN_STEPS / 3) idle_mode = IDLE_TX_HEAVY;
      else                                 idle_mode = IDLE_NONE;
      // with no idling the sender keeps pushing into a held output
      if (idle_mode == IDLE_NONE && !pressed) begin
        hold_req = 1'b1;
        pressed  = 1'b1;
      end
      pick = $urandom_range(99);
      c    = random_item();
      if (steps < SCAN_STEPS && (pick < 60 || items_sent >= TOTAL_ITEMS)) c.cmd = CMD_STEP;
      else if (pick < 85) begin
        c.cmd      = CMD_WRITE;
        c.plane[1] = ($urandom_range(9) == 0);
      end else if (pick < 93) c.cmd = CMD_PAINT;
      else c.cmd = CMD_UNUSED;
      send_command(c);
      if (c.cmd == CMD_STEP) steps++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending_beats.size() != 0) board.note_failure("beats still pending at end");
    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
